### rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Types, timing budgets and codes shared by the LCD mode/line timer.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int CYCLES_W = 8;
    localparam int COUNT_W  = 16;
    localparam int LINE_W   = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 8;
    localparam int IRQ_EN_W = 4;
    localparam int BUDGET_W = 11;

    localparam logic [BUDGET_W-1:0] HBLANK_LEN    = 11'd204;
    localparam logic [BUDGET_W-1:0] LINE_LEN      = 11'd456;
    localparam logic [BUDGET_W-1:0] SEARCH_LEN    = 11'd80;
    localparam logic [BUDGET_W-1:0] TRANSFER_LEN  = 11'd172;
    localparam logic [LINE_W-1:0]   VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0]   TOTAL_LINES   = 8'd154;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // status interrupt enable bits
    localparam int IRQ_EN_HBLANK = 0;
    localparam int IRQ_EN_VBLANK = 1;
    localparam int IRQ_EN_SEARCH = 2;
    localparam int IRQ_EN_COIN   = 3;

    // request kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_DISABLE = 1'b1;

    // configuration register indexes
    localparam logic CFG_LINE_COMPARE = 1'b0;
    localparam logic CFG_IRQ_ENABLES  = 1'b1;

    // mode codes as seen on the result channel
    localparam logic [MODE_W-1:0] MODE_CODE_HBLANK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_VBLANK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_SEARCH   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_TRANSFER = 2'd3;

    typedef enum logic [3:0] {
        MODE_HBLANK   = 4'b0001,
        MODE_VBLANK   = 4'b0010,
        MODE_SEARCH   = 4'b0100,
        MODE_TRANSFER = 4'b1000
    } t_mode;

    typedef struct packed {
        logic                kind;
        logic [CYCLES_W-1:0] cycles;
    } t_req;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              status_irq;
        logic              vblank_irq;
        logic              line_done;
        logic              frame_done;
    } t_rsp;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [LINE_W-1:0]  line;
        t_mode              mode;
        logic               coin;
    } t_state;

    typedef struct packed {
        logic [LINE_W-1:0]   line_compare;
        logic [IRQ_EN_W-1:0] irq_en;
    } t_cfg;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_HBLANK:   c = MODE_CODE_HBLANK;
            MODE_VBLANK:   c = MODE_CODE_VBLANK;
            MODE_SEARCH:   c = MODE_CODE_SEARCH;
            MODE_TRANSFER: c = MODE_CODE_TRANSFER;
            default:       c = MODE_CODE_HBLANK;
        endcase
        return c;
    endfunction

endpackage

### rtl/mlt_req_if.sv
// ----------------------------------------------------------------------------
// mlt_req_if
// Request channel of the LCD mode/line timer: tick or display disable.
// ----------------------------------------------------------------------------
interface mlt_req_if import mlt_pkg::*;;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [CYCLES_W-1:0] cycles;

    modport source (output valid, output kind, output cycles, input ready);
    modport sink   (input valid, input kind, input cycles, output ready);
endinterface

### rtl/mlt_rsp_if.sv
// ----------------------------------------------------------------------------
// mlt_rsp_if
// Result channel of the LCD mode/line timer: mode, line, flags and strobes.
// ----------------------------------------------------------------------------
interface mlt_rsp_if import mlt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              status_irq;
    logic              vblank_irq;
    logic              line_done;
    logic              frame_done;

    modport source (
        output valid, output mode, output line, output coincidence,
        output status_irq, output vblank_irq, output line_done, output frame_done,
        input  ready
    );
    modport sink (
        input  valid, input mode, input line, input coincidence,
        input  status_irq, input vblank_irq, input line_done, input frame_done,
        output ready
    );
endinterface

### rtl/mlt_step.sv
// ----------------------------------------------------------------------------
// mlt_step
// One request worth of timer update: add, saturate, budget check, mode
// transition, line advance and coincidence compare, or a disable to H-blank.
// ----------------------------------------------------------------------------
module mlt_step import mlt_pkg::*; (
    input  t_req   i_req,
    input  t_state i_state,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output t_rsp   o_rsp
);

    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] sat;
    logic [COUNT_W-1:0] budget;
    logic [COUNT_W-1:0] sub;
    logic               hit;
    logic [LINE_W-1:0]  line_inc;
    t_state             nxt;
    logic               sirq;
    logic               virq;
    logic               ldone;
    logic               fdone;

    assign sum      = {1'b0, i_state.count} + (COUNT_W+1)'(i_req.cycles);
    assign sat      = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    assign sub      = sat - budget;
    assign hit      = (sat >= budget);
    assign line_inc = i_state.line + 8'd1;

    always_comb begin
        case (i_state.mode)
            MODE_HBLANK:   budget = COUNT_W'(HBLANK_LEN);
            MODE_VBLANK:   budget = COUNT_W'(LINE_LEN);
            MODE_SEARCH:   budget = COUNT_W'(SEARCH_LEN);
            MODE_TRANSFER: budget = COUNT_W'(TRANSFER_LEN);
            default:       budget = COUNT_W'(TRANSFER_LEN);
        endcase
    end

    always_comb begin
        nxt   = i_state;
        sirq  = 1'b0;
        virq  = 1'b0;
        ldone = 1'b0;
        fdone = 1'b0;
        if (i_req.kind == KIND_DISABLE) begin
            nxt.count = '0;
            nxt.line  = '0;
            nxt.mode  = MODE_HBLANK;
            sirq      = i_cfg.irq_en[IRQ_EN_HBLANK];
        end else begin
            nxt.count = hit ? sub : sat;
            if (hit) begin
                case (i_state.mode)
                    MODE_HBLANK: begin
                        ldone    = 1'b1;
                        nxt.line = line_inc;
                        if (line_inc == VISIBLE_LINES) begin
                            virq     = 1'b1;
                            nxt.mode = MODE_VBLANK;
                            sirq     = i_cfg.irq_en[IRQ_EN_VBLANK];
                        end else begin
                            nxt.mode = MODE_SEARCH;
                            sirq     = i_cfg.irq_en[IRQ_EN_SEARCH];
                        end
                    end
                    MODE_VBLANK: begin
                        nxt.line = line_inc;
                        if (line_inc >= TOTAL_LINES) begin
                            fdone    = 1'b1;
                            nxt.line = '0;
                            nxt.mode = MODE_SEARCH;
                            sirq     = i_cfg.irq_en[IRQ_EN_SEARCH];
                        end
                    end
                    MODE_SEARCH: begin
                        nxt.mode = MODE_TRANSFER;
                    end
                    MODE_TRANSFER: begin
                        nxt.mode = MODE_HBLANK;
                        sirq     = i_cfg.irq_en[IRQ_EN_HBLANK];
                    end
                    default: begin
                        nxt.mode = MODE_HBLANK;
                    end
                endcase
            end
            nxt.coin = (nxt.line == i_cfg.line_compare);
            if (nxt.coin && i_cfg.irq_en[IRQ_EN_COIN]) begin
                sirq = 1'b1;
            end
        end
    end

    assign o_state = nxt;

    assign o_rsp.mode        = mode_code(nxt.mode);
    assign o_rsp.line        = nxt.line;
    assign o_rsp.coincidence = nxt.coin;
    assign o_rsp.status_irq  = sirq;
    assign o_rsp.vblank_irq  = virq;
    assign o_rsp.line_done   = ldone;
    assign o_rsp.frame_done  = fdone;

endmodule

### rtl/lcd_mode_line_timer_unit.sv
// ----------------------------------------------------------------------------
// lcd_mode_line_timer_unit
// Scanline and display-mode timer: input register, one-pass update, result
// register. An accepted request waits in the input register until the result
// register is free or being taken. Throughput: one request per cycle while
// results are taken, limited by the single update step.
// Synchronous active-low reset: counter and line 0, mode search, flags and
// configuration registers 0, both pipeline registers empty.
// ----------------------------------------------------------------------------
module lcd_mode_line_timer_unit import mlt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlt_req_if.sink           i_req,
    mlt_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic   r_in_valid;
    t_req   r_in;
    logic   r_out_valid;
    t_rsp   r_out;
    t_state r_state;
    t_cfg   r_cfg;

    t_state n_state;
    t_rsp   n_out;
    logic   step_go;
    logic   in_take;

    assign step_go     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || step_go;
    assign in_take     = i_req.valid && i_req.ready;

    mlt_step u_step (
        .i_req   (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_rsp   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.kind   <= i_req.kind;
            r_in.cycles <= i_req.cycles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.count <= '0;
            r_state.line  <= '0;
            r_state.mode  <= MODE_SEARCH;
            r_state.coin  <= 1'b0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_compare <= '0;
            r_cfg.irq_en       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_COMPARE: r_cfg.line_compare <= i_cfg_data;
                CFG_IRQ_ENABLES:  r_cfg.irq_en       <= i_cfg_data[IRQ_EN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.mode        = r_out.mode;
    assign o_rsp.line        = r_out.line;
    assign o_rsp.coincidence = r_out.coincidence;
    assign o_rsp.status_irq  = r_out.status_irq;
    assign o_rsp.vblank_irq  = r_out.vblank_irq;
    assign o_rsp.line_done   = r_out.line_done;
    assign o_rsp.frame_done  = r_out.frame_done;

endmodule

### bench/lcd_timing_checker.sv
// ----------------------------------------------------------------------------
// lcd_timing_checker
// Watches the request, result and register ports of the LCD mode/line timer.
// Keeps its own copy of the counter, line, mode, coincidence flag and
// registers, predicts one result per accepted request, and compares every
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_timing_checker import mlt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mlt_req_if               i_req,
    mlt_rsp_if               i_rsp,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked,
    output int               o_frames,
    output int               o_clamps,
    output int               o_coin_hits
);

    logic [COUNT_W-1:0]  tm_count;
    logic [LINE_W-1:0]   tm_line;
    logic [MODE_W-1:0]   tm_mode;
    logic                tm_coin;
    logic [LINE_W-1:0]   tm_compare;
    logic [IRQ_EN_W-1:0] tm_irq_en;

    t_rsp timer_outcomes[$];

    function automatic t_rsp advance_timer(input logic kind, input logic [CYCLES_W-1:0] cyc);
        t_rsp             r;
        logic [COUNT_W:0] sum;
        r = '0;
        if (kind == KIND_DISABLE) begin
            tm_count     = '0;
            tm_line      = '0;
            tm_mode      = MODE_CODE_HBLANK;
            r.status_irq = tm_irq_en[IRQ_EN_HBLANK];
        end else begin
            sum = {1'b0, tm_count} + {{(COUNT_W+1-CYCLES_W){1'b0}}, cyc};
            if (sum > {1'b0, COUNT_MAX}) begin
                tm_count = COUNT_MAX;
                o_clamps++;
            end else begin
                tm_count = sum[COUNT_W-1:0];
            end
            case (tm_mode)
                MODE_CODE_HBLANK: begin
                    if (tm_count >= COUNT_W'(HBLANK_LEN)) begin
                        r.line_done = 1'b1;
                        tm_count    = tm_count - COUNT_W'(HBLANK_LEN);
                        tm_line     = tm_line + 8'd1;
                        if (tm_line == VISIBLE_LINES) begin
                            r.vblank_irq = 1'b1;
                            r.status_irq = tm_irq_en[IRQ_EN_VBLANK];
                            tm_mode      = MODE_CODE_VBLANK;
                        end else begin
                            r.status_irq = tm_irq_en[IRQ_EN_SEARCH];
                            tm_mode      = MODE_CODE_SEARCH;
                        end
                    end
                end
                MODE_CODE_VBLANK: begin
                    if (tm_count >= COUNT_W'(LINE_LEN)) begin
                        tm_count = tm_count - COUNT_W'(LINE_LEN);
                        tm_line  = tm_line + 8'd1;
                        if (tm_line >= TOTAL_LINES) begin
                            r.frame_done = 1'b1;
                            tm_line      = '0;
                            r.status_irq = tm_irq_en[IRQ_EN_SEARCH];
                            tm_mode      = MODE_CODE_SEARCH;
                        end
                    end
                end
                MODE_CODE_SEARCH: begin
                    if (tm_count >= COUNT_W'(SEARCH_LEN)) begin
                        tm_count = tm_count - COUNT_W'(SEARCH_LEN);
                        tm_mode  = MODE_CODE_TRANSFER;
                    end
                end
                default: begin
                    if (tm_count >= COUNT_W'(TRANSFER_LEN)) begin
                        tm_count     = tm_count - COUNT_W'(TRANSFER_LEN);
                        r.status_irq = tm_irq_en[IRQ_EN_HBLANK];
                        tm_mode      = MODE_CODE_HBLANK;
                    end
                end
            endcase
            tm_coin = (tm_line == tm_compare);
            if (tm_coin && tm_irq_en[IRQ_EN_COIN])
                r.status_irq = 1'b1;
        end
        r.mode        = tm_mode;
        r.line        = tm_line;
        r.coincidence = tm_coin;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            tm_count   = '0;
            tm_line    = '0;
            tm_mode    = MODE_CODE_SEARCH;
            tm_coin    = 1'b0;
            tm_compare = '0;
            tm_irq_en  = '0;
            timer_outcomes.delete();
            o_errors    = 0;
            o_checked   = 0;
            o_frames    = 0;
            o_clamps    = 0;
            o_coin_hits = 0;
        end else begin
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_idx == CFG_LINE_COMPARE)
                    tm_compare = i_cfg_data[LINE_W-1:0];
                else
                    tm_irq_en = i_cfg_data[IRQ_EN_W-1:0];
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                timer_outcomes.push_back(advance_timer(i_req.kind, i_req.cycles));
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (timer_outcomes.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with no request outstanding, expected none, got %0h/%0h",
                             $time, i_rsp.mode, i_rsp.line);
                end else begin
                    want = timer_outcomes.pop_front();
                    check_field("mode", 8'(want.mode), 8'(i_rsp.mode));
                    check_field("line", want.line, i_rsp.line);
                    check_field("coincidence", 8'(want.coincidence), 8'(i_rsp.coincidence));
                    check_field("status_irq", 8'(want.status_irq), 8'(i_rsp.status_irq));
                    check_field("vblank_irq", 8'(want.vblank_irq), 8'(i_rsp.vblank_irq));
                    check_field("line_done", 8'(want.line_done), 8'(i_rsp.line_done));
                    check_field("frame_done", 8'(want.frame_done), 8'(i_rsp.frame_done));
                    o_checked++;
                    if (want.frame_done)
                        o_frames++;
                    if (want.coincidence)
                        o_coin_hits++;
                end
            end
        end
        o_pending = timer_outcomes.size();
    end

endmodule

### bench/tb_lcd_mode_line_timer_unit.sv
// ----------------------------------------------------------------------------
// tb_lcd_mode_line_timer_unit
// Stimulus and verdict for the LCD mode/line timer. Runs a directed set of
// ticks and disables over budget edges, a long run of large ticks that wraps
// a frame and saturates the counter, then random phases with fresh register
// settings. Both channels idle at random; checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_lcd_mode_line_timer_unit;
    import mlt_pkg::*;

    localparam int RUN_LIMIT = 1000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    int  errors, pending, checked, frames, clamps, coin_hits;
    int  cycle_cnt;
    bit  gaps_on;

    mlt_req_if req_if();
    mlt_rsp_if rsp_if();

    lcd_mode_line_timer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lcd_timing_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_frames    (frames),
        .o_clamps    (clamps),
        .o_coin_hits (coin_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin : rsp_stall
        int run, hold;
        rsp_if.ready = 1'b0;
        forever begin
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            @(negedge i_clk) rsp_if.ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            @(negedge i_clk) rsp_if.ready <= 1'b0;
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CYCLES_W-1:0] random_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CYCLES_W'($urandom_range(0, 255));
        else if (r < 70)
            return CYCLES_W'($urandom_range(150, 255));
        else if (r < 85)
            return CYCLES_W'($urandom_range(0, 10));
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_request(input logic kind, input logic [CYCLES_W-1:0] cyc);
        int gap;
        req_if.valid  <= 1'b1;
        req_if.kind   <= kind;
        req_if.cycles <= cyc;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid  <= 1'b0;
            req_if.kind   <= 1'($urandom);
            req_if.cycles <= CYCLES_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int r;
        logic [CFG_W-1:0] cmp;
        req_if.valid  = 1'b0;
        req_if.kind   = KIND_TICK;
        req_if.cycles = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_LINE_COMPARE;
        cfg_data      = '0;
        i_rst_n       = 1'b0;
        gaps_on       = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: budget edges, exact hits, repeated disables
        write_reg(CFG_LINE_COMPARE, 8'h00);
        write_reg(CFG_IRQ_ENABLES, 8'hFF);
        send_request(KIND_TICK, 8'd0);
        send_request(KIND_TICK, 8'd255);
        send_request(KIND_TICK, 8'd255);
        send_request(KIND_TICK, 8'd0);
        send_request(KIND_DISABLE, 8'hAA);
        send_request(KIND_DISABLE, 8'h55);
        send_request(KIND_TICK, 8'h80);
        send_request(KIND_TICK, 8'h7F);
        send_request(KIND_TICK, 8'd29);
        send_request(KIND_TICK, 8'd171);
        send_request(KIND_TICK, 8'd1);
        send_request(KIND_TICK, 8'd203);
        send_request(KIND_TICK, 8'd1);
        send_request(KIND_TICK, 8'd0);
        send_request(KIND_DISABLE, 8'hFF);
        send_request(KIND_TICK, 8'd255);
        wait_drained();

        // long run of large ticks: full frame, then counter saturation
        write_reg(CFG_LINE_COMPARE, 8'd100);
        write_reg(CFG_IRQ_ENABLES, 8'h02);
        repeat (380) send_request(KIND_TICK, CYCLES_W'($urandom_range(250, 255)));
        wait_drained();
        write_reg(CFG_LINE_COMPARE, 8'd153);
        write_reg(CFG_IRQ_ENABLES, 8'h0F);
        repeat (380) send_request(KIND_TICK, CYCLES_W'($urandom_range(250, 255)));
        wait_drained();

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            r = $urandom_range(0, 3);
            cmp = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                  (r == 2) ? CFG_W'($urandom_range(0, 153)) : CFG_W'($urandom_range(0, 255));
            write_reg(CFG_LINE_COMPARE, cmp);
            write_reg(CFG_IRQ_ENABLES, CFG_W'($urandom_range(0, 255)));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 165; n++) begin
                if ($urandom_range(0, 149) == 0)
                    send_request(KIND_DISABLE, CYCLES_W'($urandom));
                else
                    send_request(KIND_TICK, random_cycles());
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
            wait_drained();
            gaps_on = 1'b1;
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        $display("Checked %0d results over %0d completed frames.", checked, frames);
        $display("Counter saturated %0d times; coincidence held on %0d results.",
                 clamps, coin_hits);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/mlt_pkg.sv
rtl/mlt_req_if.sv
rtl/mlt_rsp_if.sv
rtl/mlt_step.sv
rtl/lcd_mode_line_timer_unit.sv
bench/lcd_timing_checker.sv
bench/tb_lcd_mode_line_timer_unit.sv
